[design/cht_pkg.sv]
// cht_pkg: shared codes for the chained hash table core
// command and status encodings used by the channel interfaces and the core
// no dependencies
package cht_pkg;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_REPLACED  = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

endpackage

[design/cht_if.sv]
// cht_if: valid/ready channel interfaces of the chained hash table core
// request channel (command, key, payload) and response channel (status, empty flag)
// depends on cht_pkg
interface cht_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] key;
	logic [31:0] payload;

	modport source (output valid, output cmd, output key, output payload, input ready);
	modport sink   (input valid, input cmd, input key, input payload, output ready);
endinterface

interface cht_rsp_if import cht_pkg::*;;
	logic    valid;
	logic    ready;
	status_t status;
	logic    table_empty;

	modport source (output valid, output status, output table_empty, input ready);
	modport sink   (input valid, input status, input table_empty, output ready);
endinterface

[design/chained_hash_table_core.sv]
// chained_hash_table_core: keyed store, key mod NUM_BUCKETS selects a bucket of slots
// one shared 32x17 multiplier finds the bucket by reciprocal, one key comparator scans slots
// depends on cht_pkg and cht_if
//
//  channel | dir | beat contents             | accepted when
//  req     | in  | cmd, key, payload         | req.valid && req.ready
//  rsp     | out | status, table_empty       | rsp.valid && rsp.ready
//
// an item passes S_MUL0, S_MUL1 and S_MUL2 for the bucket index, then S_VRD, then one slot key
// read (S_KRD) and compare (S_CMP) per slot, then S_WR; a key hit ends the slot scan early
// after reset a clearing pass zeroes the valid row of every bucket, req.ready stays low
// req.ready is high whenever the sequencer is idle, even while a response beat waits
// a stalled response holds the write-back step until the output register frees up
module chained_hash_table_core import cht_pkg::*; #(
	parameter int NUM_BUCKETS   = 16,
	parameter int BUCKET_SLOTS  = 4,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	cht_req_if.sink    req,
	cht_rsp_if.source  rsp
);

	localparam int TOTAL = NUM_BUCKETS * BUCKET_SLOTS;
	localparam int TW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int SW    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int CW    = $clog2(TOTAL + 1);
	localparam int LG    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 0;
	localparam int MUL_S = 32 + LG;
	localparam int AW    = MUL_S + 32;

	localparam logic [SW-1:0] LAST_SLOT   = SW'(BUCKET_SLOTS - 1);
	localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);
	localparam logic [CW-1:0] CNT_MAX     = CW'(TOTAL);

	// rounded-up reciprocal of the bucket count, exact quotient for any 32-bit key
	localparam logic [33:0] MREC = 34'(((64'd1 << MUL_S) + 64'(NUM_BUCKETS) - 64'd1) /
		64'(NUM_BUCKETS));
	localparam logic [16:0] M_LO = MREC[16:0];
	localparam logic [16:0] M_HI = MREC[33:17];
	localparam logic [16:0] NB17 = 17'(NUM_BUCKETS);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_VRD, S_KRD, S_CMP, S_WR
	} state_t;

	state_t                   state_q;
	logic [BW-1:0]            clr_q;
	logic                     cmd_q;
	logic [31:0]              key_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic [AW-1:0]            acc_q;
	logic [BW-1:0]            bucket_q;
	logic [SW-1:0]            slot_q;
	logic                     hit_v_q;
	logic [SW-1:0]            hit_s_q;
	logic                     free_v_q;
	logic [SW-1:0]            free_s_q;
	logic [CW-1:0]            cnt_q;
	logic                     out_valid_q;
	status_t                  status_q;
	logic                     empty_q;

	logic [BUCKET_SLOTS-1:0]  vrow_q;
	logic [31:0]              kdata_q;

	logic [BUCKET_SLOTS-1:0]  vmem [NUM_BUCKETS];
	logic [31:0]              kmem [TOTAL];
	logic [PAYLOAD_WIDTH-1:0] dmem [TOTAL];

	logic [63:0]              pay_ext;
	logic [31:0]              quo;
	logic [31:0]              mul_a;
	logic [16:0]              mul_b;
	logic [48:0]              mul_p;
	logic [TW-1:0]            base;
	logic [TW-1:0]            raddr;
	logic [TW-1:0]            waddr;
	logic                     match;
	logic                     wr_go;
	logic [SW-1:0]            wslot;
	logic                     key_we;
	logic                     data_we;
	logic                     vmem_we;
	logic [BW-1:0]            vmem_addr;
	logic [BUCKET_SLOTS-1:0]  vmem_wdata;
	logic [BUCKET_SLOTS-1:0]  vrow_upd;
	logic                     vrow_we;
	logic [CW-1:0]            cnt_nxt;
	status_t                  st_nxt;

	assign pay_ext = {32'd0, req.payload};
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.table_empty = empty_q;

	// shared multiplier: key times reciprocal halves, then quotient times bucket count
	assign quo = acc_q[MUL_S +: 32];

	always_comb begin
		mul_a = key_q;
		mul_b = M_LO;
		if (state_q == S_MUL1) begin
			mul_b = M_HI;
		end else if (state_q == S_MUL2) begin
			mul_a = quo;
			mul_b = NB17;
		end
	end

	assign mul_p = 49'(mul_a) * 49'(mul_b);

	assign base  = TW'(32'(bucket_q) * BUCKET_SLOTS);
	assign raddr = base + TW'(slot_q);
	assign waddr = base + TW'(wslot);
	assign match = vrow_q[slot_q] && (kdata_q == key_q);
	assign wr_go = (state_q == S_WR) && (!out_valid_q || rsp.ready);

	// write-back decision
	always_comb begin
		st_nxt   = ST_FULL;
		wslot    = hit_s_q;
		key_we   = 1'b0;
		data_we  = 1'b0;
		vrow_we  = 1'b0;
		vrow_upd = vrow_q;
		cnt_nxt  = cnt_q;
		if (cmd_q == CMD_INSERT) begin
			if (hit_v_q) begin
				st_nxt  = ST_REPLACED;
				data_we = wr_go;
			end else if (free_v_q) begin
				st_nxt           = ST_INSERTED;
				wslot            = free_s_q;
				key_we           = wr_go;
				data_we          = wr_go;
				vrow_we          = wr_go;
				vrow_upd[free_s_q] = 1'b1;
				cnt_nxt          = cnt_q + 1'b1;
			end else begin
				st_nxt = ST_FULL;
			end
		end else begin
			if (hit_v_q) begin
				st_nxt            = ST_REMOVED;
				vrow_we           = wr_go;
				vrow_upd[hit_s_q] = 1'b0;
				cnt_nxt           = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
			end else begin
				st_nxt = ST_NOT_FOUND;
			end
		end
	end

	always_comb begin
		vmem_we    = vrow_we;
		vmem_addr  = bucket_q;
		vmem_wdata = vrow_upd;
		if (state_q == S_CLEAR) begin
			vmem_we    = 1'b1;
			vmem_addr  = clr_q;
			vmem_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_VRD) begin
			vrow_q <= vmem[bucket_q];
		end
		if (state_q == S_KRD) begin
			kdata_q <= kmem[raddr];
		end
		if (vmem_we) begin
			vmem[vmem_addr] <= vmem_wdata;
		end
		if (key_we) begin
			kmem[waddr] <= key_q;
		end
		if (data_we) begin
			dmem[waddr] <= pay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_BUCKET) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						key_q   <= req.key;
						pay_q   <= pay_ext[PAYLOAD_WIDTH-1:0];
						state_q <= S_MUL0;
					end
				end
				S_MUL0: begin
					acc_q   <= AW'(mul_p);
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					acc_q   <= acc_q + (AW'(mul_p) << 17);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					bucket_q <= BW'(key_q - mul_p[31:0]);
					state_q  <= S_VRD;
				end
				S_VRD: begin
					slot_q   <= '0;
					hit_v_q  <= 1'b0;
					free_v_q <= 1'b0;
					state_q  <= S_KRD;
				end
				S_KRD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (match) begin
						hit_v_q <= 1'b1;
						hit_s_q <= slot_q;
						state_q <= S_WR;
					end else begin
						if (!vrow_q[slot_q] && !free_v_q) begin
							free_v_q <= 1'b1;
							free_s_q <= slot_q;
						end
						if (slot_q == LAST_SLOT) begin
							state_q <= S_WR;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_KRD;
						end
					end
				end
				S_WR: begin
					if (wr_go) begin
						cnt_q    <= cnt_nxt;
						status_q <= st_nxt;
						empty_q  <= (cnt_nxt == '0);
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above table size");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_WR) |=> (cnt_q == $past(cnt_q)))
		else $error("entry count changed outside write-back");

	a_insert_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_INSERTED) |-> !rsp.table_empty)
		else $error("empty flag set after an insert");

	a_wr_beat: assert property (@(posedge clk) disable iff (!arst_n)
		wr_go |=> (out_valid_q && state_q == S_IDLE))
		else $error("write-back did not load a response beat");
`endif

endmodule

[sim/testbench.sv]
// testbench: self-checking bench for chained_hash_table_core, insert/remove beats with
// a behavioral shadow of the buckets, directed rows followed by random rounds and drains
// depends on cht_pkg, cht_if and chained_hash_table_core
module testbench import cht_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BUCKETS   = 16;
	localparam int BUCKET_SLOTS  = 4;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int TOTAL_SLOTS   = NUM_BUCKETS * BUCKET_SLOTS;
	localparam int POOL_SIZE     = 32;
	localparam int STALL_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 64;
	localparam int NUM_ROWS      = 25;
	localparam int NUM_ROUNDS    = 4;

	typedef struct {
		status_t status;
		logic    table_empty;
	} op_result_t;

	typedef struct {
		logic        cmd;
		logic [31:0] key;
		logic [31:0] payload;
		bit          typed;
		status_t     status;
		bit          table_empty;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	cht_req_if req_ch();
	cht_rsp_if rsp_ch();

	chained_hash_table_core #(
		.NUM_BUCKETS  (NUM_BUCKETS),
		.BUCKET_SLOTS (BUCKET_SLOTS),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #4 clk = ~clk;

	// shadow of the bucket store
	logic [31:0] held_key [TOTAL_SLOTS];
	bit          held_valid [TOTAL_SLOTS];
	int          held_count;

	op_result_t  pending_rsp[$];
	logic [31:0] key_pool [POOL_SIZE];
	dir_row_t    dir_rows [NUM_ROWS];

	int errors        = 0;
	int idle_cycles   = 0;
	int send_idle_pct = 30;
	int rsp_stall_pct = 30;
	bit quiet         = 1'b0;

	function automatic void apply_op(input logic cmd, input logic [31:0] key,
			output status_t status, output logic table_empty);
		int base;
		int hit;
		base = (key % NUM_BUCKETS) * BUCKET_SLOTS;
		hit = -1;
		for (int s = 0; s < BUCKET_SLOTS; s++) begin
			if (hit < 0 && held_valid[base + s] && held_key[base + s] == key)
				hit = base + s;
		end
		if (cmd == CMD_INSERT) begin
			if (hit >= 0) begin
				status = ST_REPLACED;
			end else begin
				status = ST_FULL;
				for (int s = 0; s < BUCKET_SLOTS; s++) begin
					if (status == ST_FULL && !held_valid[base + s]) begin
						held_valid[base + s] = 1'b1;
						held_key[base + s] = key;
						held_count++;
						status = ST_INSERTED;
					end
				end
			end
		end else begin
			if (hit >= 0) begin
				held_valid[hit] = 1'b0;
				held_count--;
				status = ST_REMOVED;
			end else begin
				status = ST_NOT_FOUND;
			end
		end
		table_empty = (held_count == 0);
	endfunction

	function automatic logic [31:0] pick_key();
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic send_op(input logic cmd, input logic [31:0] key, input logic [31:0] payload,
			input bit typed, input status_t typed_status, input bit typed_empty);
		int gap;
		op_result_t res;
		gap = 0;
		if (!quiet && $urandom_range(99) < send_idle_pct)
			gap = $urandom_range(1, 16);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid   <= 1'b1;
		req_ch.cmd     <= cmd;
		req_ch.key     <= key;
		req_ch.payload <= payload;
		do @(posedge clk); while (!req_ch.ready);
		apply_op(cmd, key, res.status, res.table_empty);
		if (typed) begin
			res.status = typed_status;
			res.table_empty = typed_empty;
		end
		pending_rsp.push_back(res);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// response check
	always @(posedge clk) begin
		op_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: status %0d empty %b", rsp_ch.status,
						rsp_ch.table_empty);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.table_empty !== want.table_empty) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: status exp %0d got %0d, empty exp %b got %b",
							want.status, rsp_ch.status, want.table_empty,
							rsp_ch.table_empty);
				end
			end
		end
	end

	// watchdog on beats from either side
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// response back-pressure
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(99) < rsp_stall_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		int items_by_round [NUM_ROUNDS];
		int idle_by_round [NUM_ROUNDS];
		int ins_pct;
		logic [31:0] drain_keys[$];
		logic cmd;

		items_by_round = '{175, 175, 175, 125};
		idle_by_round  = '{30, 0, 55, 0};
		dir_rows = '{
			'{CMD_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, ST_NOT_FOUND, 1},
			'{CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 1, ST_INSERTED,  0},
			'{CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1, ST_REPLACED,  0},
			'{CMD_INSERT, 32'h0000_0010, 32'hA5A5_A5A5, 1, ST_INSERTED,  0},
			'{CMD_INSERT, 32'h0000_0020, 32'h5A5A_5A5A, 1, ST_INSERTED,  0},
			'{CMD_INSERT, 32'h0000_0030, 32'h1234_5678, 1, ST_INSERTED,  0},
			'{CMD_INSERT, 32'h0000_0040, 32'h0000_0001, 1, ST_FULL,      0},
			'{CMD_INSERT, 32'h0000_0030, 32'h0000_0001, 1, ST_REPLACED,  0},
			'{CMD_REMOVE, 32'h0000_0040, 32'h0000_0000, 1, ST_NOT_FOUND, 0},
			'{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_INSERTED,  0},
			'{CMD_REMOVE, 32'hFFFF_FFEF, 32'h0000_0000, 1, ST_NOT_FOUND, 0},
			'{CMD_REMOVE, 32'h0000_0010, 32'h0000_0000, 1, ST_REMOVED,   0},
			'{CMD_INSERT, 32'h0000_0040, 32'h0000_0000, 0, ST_INSERTED,  0},
			'{CMD_INSERT, 32'h0000_0050, 32'h8000_0000, 1, ST_FULL,      0},
			'{CMD_REMOVE, 32'h0000_0010, 32'h0000_0000, 1, ST_NOT_FOUND, 0},
			'{CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 0, ST_INSERTED,  0},
			'{CMD_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, ST_REMOVED,   0},
			'{CMD_REMOVE, 32'h0000_0020, 32'h0000_0000, 1, ST_REMOVED,   0},
			'{CMD_REMOVE, 32'h0000_0030, 32'h0000_0000, 1, ST_REMOVED,   0},
			'{CMD_REMOVE, 32'h0000_0040, 32'h0000_0000, 1, ST_REMOVED,   0},
			'{CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_REMOVED,   0},
			'{CMD_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1, ST_REMOVED,   1},
			'{CMD_INSERT, 32'h8000_0000, 32'h0000_0000, 1, ST_INSERTED,  0},
			'{CMD_REMOVE, 32'h8000_0000, 32'hFFFF_FFFF, 1, ST_REMOVED,   1},
			'{CMD_REMOVE, 32'h0000_0005, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 1}
		};

		for (int e = 0; e < TOTAL_SLOTS; e++) begin
			held_valid[e] = 1'b0;
			held_key[e] = '0;
		end
		held_count = 0;

		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.cmd     <= CMD_INSERT;
		req_ch.key     <= '0;
		req_ch.payload <= '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_op(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].payload,
				dir_rows[i].typed, dir_rows[i].status, dir_rows[i].table_empty);

		for (int rnd = 0; rnd < NUM_ROUNDS; rnd++) begin
			send_idle_pct = idle_by_round[rnd];
			rsp_stall_pct = idle_by_round[rnd];
			quiet = (rnd == NUM_ROUNDS - 1);
			// crowd the keys into buckets 0 to 7 so chains fill up
			for (int p = 0; p < POOL_SIZE; p++)
				key_pool[p] = {28'($urandom), 4'(0)} | 32'($urandom_range(0, 7));
			for (int i = 0; i < items_by_round[rnd]; i++) begin
				ins_pct = (i < items_by_round[rnd] / 2) ? 75 : 35;
				cmd = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
				send_op(cmd, pick_key(), $urandom, 0, ST_INSERTED, 0);
			end
			// hold off until every response is back, then empty the store
			wait_drained();
			drain_keys.delete();
			for (int e = 0; e < TOTAL_SLOTS; e++)
				if (held_valid[e])
					drain_keys.push_back(held_key[e]);
			foreach (drain_keys[k])
				send_op(CMD_REMOVE, drain_keys[k], $urandom, 0, ST_INSERTED, 0);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
